### rtl/hsvkey_pkg.sv
// Shared types and constants for the RGB to HSV color key pipeline.
// Used by every module of the block; depends on nothing else.
package hsvkey_pkg;

  // Default fraction widths for hue and saturation.
  localparam int HUE_FRAC_DEF = 6;
  localparam int SAT_FRAC_DEF = 8;

  // Quotient bits resolved by each divider stage.
  localparam int DIV_STEPS = 4;

  // Port widths of the result fields.
  localparam int HUE_W = 15;
  localparam int SAT_W = 9;
  localparam int BYTE_W = 8;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_HUE_LOW = 3'd0;
  localparam logic [2:0] REG_HUE_HIGH = 3'd1;
  localparam logic [2:0] REG_SAT_LOW = 3'd2;
  localparam logic [2:0] REG_SAT_HIGH = 3'd3;
  localparam logic [2:0] REG_VALUE_CUTOFF = 3'd4;

  // Register reset values.
  localparam logic [HUE_W-1:0] HUE_LOW_RST = 15'd2560;
  localparam logic [HUE_W-1:0] HUE_HIGH_RST = 15'd6400;
  localparam logic [SAT_W-1:0] SAT_LOW_RST = 9'd102;
  localparam logic [SAT_W-1:0] SAT_HIGH_RST = 9'd256;
  localparam logic [BYTE_W-1:0] VALUE_CUTOFF_RST = 8'd128;

  // Which channel holds the largest byte.
  localparam logic [1:0] SECT_RED = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE = 2'd2;

  // Key windows and cutoff.
  typedef struct packed {
    logic [HUE_W-1:0] hue_low;
    logic [HUE_W-1:0] hue_high;
    logic [SAT_W-1:0] sat_low;
    logic [SAT_W-1:0] sat_high;
    logic [BYTE_W-1:0] value_cutoff;
  } cfg_t;

  // Per-pixel facts that travel alongside the dividers.
  typedef struct packed {
    logic gray;
    logic neg;
    logic [1:0] sector;
    logic [BYTE_W-1:0] mx;
  } side_t;

endpackage

### rtl/hsvkey_front.sv
// Front end: max/min search, hue sector and numerator scaling (two stages).
// Depends on hsvkey_pkg.
module hsvkey_front
  import hsvkey_pkg::*;
#(
  parameter int HFB = HUE_FRAC_DEF,
  parameter int SFB = SAT_FRAC_DEF,
  parameter int XHW = 20,
  parameter int XSW = 16
) (
  input  logic clk,
  input  logic en_a,
  input  logic en_b,
  input  logic [BYTE_W-1:0] red,
  input  logic [BYTE_W-1:0] green,
  input  logic [BYTE_W-1:0] blue,
  output logic [XHW-1:0] xh,
  output logic [XSW-1:0] xs,
  output logic [BYTE_W-1:0] dh,
  output logic [BYTE_W-1:0] dm,
  output side_t side
);

  localparam int UNIT = 60 << HFB;

  logic [BYTE_W-1:0] mx_c, mn_c, p1_c, p2_c;
  logic [1:0] sector_c;
  logic neg_c;

  logic [BYTE_W-1:0] a_q, d_q, mx_q;
  logic [1:0] sector_q;
  logic neg_q;
  logic gray_c;

  // Pick the largest channel, red first, then green; its two partners
  // form the signed hue numerator.
  always_comb begin
    if (red >= green && red >= blue) begin
      sector_c = SECT_RED;
      mx_c = red;
      p1_c = green;
      p2_c = blue;
    end else if (green >= blue) begin
      sector_c = SECT_GREEN;
      mx_c = green;
      p1_c = blue;
      p2_c = red;
    end else begin
      sector_c = SECT_BLUE;
      mx_c = blue;
      p1_c = red;
      p2_c = green;
    end
    mn_c = (red <= green) ? red : green;
    mn_c = (mn_c <= blue) ? mn_c : blue;
    neg_c = p1_c < p2_c;
  end

  // Stage A: magnitude of the numerator, spread and maximum.
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_q <= neg_c ? BYTE_W'(p2_c - p1_c) : BYTE_W'(p1_c - p2_c);
      d_q <= BYTE_W'(mx_c - mn_c);
      mx_q <= mx_c;
      sector_q <= sector_c;
      neg_q <= neg_c;
    end
  end

  assign gray_c = (d_q == '0);

  // Stage B: scaled dividends; a gray pixel divides zero by one.
  always_ff @(posedge clk) begin
    if (en_b) begin
      xh <= XHW'(a_q) * XHW'(UNIT);
      xs <= {d_q, {SFB{1'b0}}};
      dh <= gray_c ? BYTE_W'(1) : d_q;
      dm <= gray_c ? BYTE_W'(1) : mx_q;
      side <= '{gray: gray_c, neg: neg_q, sector: sector_q, mx: mx_q};
    end
  end

endmodule

### rtl/hsvkey_div.sv
// Pipelined restoring divider by an 8-bit divisor, a few quotient bits per stage.
// Depends on hsvkey_pkg.
module hsvkey_div
  import hsvkey_pkg::*;
#(
  parameter int XW = 20,
  parameter int QWP = 12,
  parameter int NS = 3
) (
  input  logic clk,
  input  logic [NS-1:0] en,
  input  logic [XW-1:0] num,
  input  logic [BYTE_W-1:0] den,
  output logic [QWP-1:0] quo,
  output logic rem_nz
);

  localparam int SPS = QWP / NS;
  localparam int EW = QWP + BYTE_W;

  logic [EW-1:0] num_ext;
  logic [BYTE_W-1:0] rem_q [NS];
  logic [QWP-1:0] low_q [NS];
  logic [QWP-1:0] quo_q [NS];
  logic [BYTE_W-1:0] den_q [NS];

  logic [BYTE_W-1:0] rem_in [NS];
  logic [QWP-1:0] low_in [NS];
  logic [QWP-1:0] quo_in [NS];
  logic [BYTE_W-1:0] den_in [NS];

  // The quotient fits in QWP bits, so the top of the dividend is
  // already below the divisor and seeds the partial remainder.
  assign num_ext = EW'(num);

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [BYTE_W-1:0] rem_c;
    logic [QWP-1:0] low_c;
    logic [QWP-1:0] quo_c;
    logic [BYTE_W:0] trial;

    if (k == 0) begin : g_first
      assign rem_in[k] = num_ext[EW-1:QWP];
      assign low_in[k] = num_ext[QWP-1:0];
      assign quo_in[k] = '0;
      assign den_in[k] = den;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign low_in[k] = low_q[k-1];
      assign quo_in[k] = quo_q[k-1];
      assign den_in[k] = den_q[k-1];
    end

    // Shift in one dividend bit per step and subtract when it fits.
    always_comb begin
      rem_c = rem_in[k];
      low_c = low_in[k];
      quo_c = quo_in[k];
      trial = '0;
      for (int s = 0; s < SPS; s++) begin
        trial = {rem_c, low_c[QWP-1]};
        low_c = {low_c[QWP-2:0], 1'b0};
        if (trial >= {1'b0, den_in[k]}) begin
          rem_c = BYTE_W'(trial - {1'b0, den_in[k]});
          quo_c = {quo_c[QWP-2:0], 1'b1};
        end else begin
          rem_c = trial[BYTE_W-1:0];
          quo_c = {quo_c[QWP-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_q[k] <= rem_c;
        low_q[k] <= low_c;
        quo_q[k] <= quo_c;
        den_q[k] <= den_in[k];
      end
    end
  end

  assign quo = quo_q[NS-1];
  assign rem_nz = (rem_q[NS-1] != '0);

endmodule

### rtl/hsvkey_key.sv
// Output stage: hue assembly from the sector offset, key windows and result register.
// Depends on hsvkey_pkg.
module hsvkey_key
  import hsvkey_pkg::*;
#(
  parameter int HFB = HUE_FRAC_DEF,
  parameter int SFB = SAT_FRAC_DEF,
  parameter int QWP = 12
) (
  input  logic clk,
  input  logic en,
  input  logic [QWP-1:0] q_hue,
  input  logic nz_hue,
  input  logic [QWP-1:0] q_sat,
  input  side_t side,
  input  cfg_t cfg,
  output logic [HUE_W-1:0] hue,
  output logic [SAT_W-1:0] saturation,
  output logic [BYTE_W-1:0] brightness,
  output logic [BYTE_W-1:0] key_intensity
);

  localparam int UNIT = 60 << HFB;
  localparam int HW = $clog2(6 * UNIT);
  localparam int SW = SFB + 1;
  localparam int HCW = (HW > HUE_W) ? HW : HUE_W;
  localparam int SCW = (SW > SAT_W) ? SW : SAT_W;

  logic [HW-1:0] base;
  logic [HW-1:0] hq;
  logic [HW-1:0] hue_full;
  logic [SW-1:0] sat_full;
  logic pass;

  // Sector offset: red wraps to 360 degrees when its numerator is negative.
  always_comb begin
    case (side.sector)
      SECT_RED: base = side.neg ? HW'(6 * UNIT) : '0;
      SECT_GREEN: base = HW'(2 * UNIT);
      SECT_BLUE: base = HW'(4 * UNIT);
      default: base = '0;
    endcase
  end

  // A negative numerator rounds down, so a nonzero remainder takes one more.
  always_comb begin
    hq = HW'(q_hue);
    if (side.gray) begin
      hue_full = '0;
    end else if (side.neg) begin
      hue_full = base - hq - HW'(nz_hue);
    end else begin
      hue_full = base + hq;
    end
    sat_full = side.gray ? '0 : SW'(q_sat);
  end

  // Window tests on the full-width values.
  assign pass = (HCW'(hue_full) >= HCW'(cfg.hue_low)) &&
                (HCW'(hue_full) <= HCW'(cfg.hue_high)) &&
                (SCW'(sat_full) >= SCW'(cfg.sat_low)) &&
                (SCW'(sat_full) <= SCW'(cfg.sat_high)) &&
                (side.mx >= cfg.value_cutoff);

  always_ff @(posedge clk) begin
    if (en) begin
      hue <= HUE_W'(hue_full);
      saturation <= SAT_W'(sat_full);
      brightness <= side.mx;
      key_intensity <= pass ? side.mx : '0;
    end
  end

endmodule

### rtl/rgb_to_hsv_color_key.sv
// RGB24 to HSV conversion with a hue/saturation/value color key.
// Pipeline: front end stages A and B, then the divider stages, then the key output register.
// Throughput: one pixel per clock while out_stall is low; the divider stages set the depth.
// Reset clears every stage valid bit and loads the register defaults.
// Depends on hsvkey_pkg, hsvkey_front, hsvkey_div and hsvkey_key.
module rgb_to_hsv_color_key
  import hsvkey_pkg::*;
#(
  parameter int HFB = HUE_FRAC_DEF,
  parameter int SFB = SAT_FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [BYTE_W-1:0] red,
  input  logic [BYTE_W-1:0] green,
  input  logic [BYTE_W-1:0] blue,
  output logic out_valid,
  input  logic out_stall,
  output logic [HUE_W-1:0] hue,
  output logic [SAT_W-1:0] saturation,
  output logic [BYTE_W-1:0] brightness,
  output logic [BYTE_W-1:0] key_intensity,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic pready
);

  localparam int UNIT = 60 << HFB;
  localparam int QWH = $clog2(UNIT + 1);
  localparam int QWS = SFB + 1;
  localparam int QWM = (QWH > QWS) ? QWH : QWS;
  localparam int NS = (QWM + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QWP = NS * DIV_STEPS;
  localparam int XHW = QWH + BYTE_W;
  localparam int XSW = SFB + BYTE_W;
  localparam int NV = NS + 3;

  cfg_t cfg;
  logic [2:0] reg_idx;
  logic wr_en;

  logic [NV-1:0] vld;
  logic [NV-1:0] en;

  logic [XHW-1:0] xh;
  logic [XSW-1:0] xs;
  logic [BYTE_W-1:0] dh, dm;
  side_t side_b;
  side_t side_p [NS];

  logic [QWP-1:0] q_hue, q_sat;
  logic nz_hue;
  logic nz_sat;

  // Configuration registers.
  assign pready = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_low <= HUE_LOW_RST;
      cfg.hue_high <= HUE_HIGH_RST;
      cfg.sat_low <= SAT_LOW_RST;
      cfg.sat_high <= SAT_HIGH_RST;
      cfg.value_cutoff <= VALUE_CUTOFF_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HUE_LOW: cfg.hue_low <= pwdata[HUE_W-1:0];
        REG_HUE_HIGH: cfg.hue_high <= pwdata[HUE_W-1:0];
        REG_SAT_LOW: cfg.sat_low <= pwdata[SAT_W-1:0];
        REG_SAT_HIGH: cfg.sat_high <= pwdata[SAT_W-1:0];
        REG_VALUE_CUTOFF: cfg.value_cutoff <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read decode.
  always_comb begin
    unique case (reg_idx)
      REG_HUE_LOW: prdata = DATA_W'(cfg.hue_low);
      REG_HUE_HIGH: prdata = DATA_W'(cfg.hue_high);
      REG_SAT_LOW: prdata = DATA_W'(cfg.sat_low);
      REG_SAT_HIGH: prdata = DATA_W'(cfg.sat_high);
      REG_VALUE_CUTOFF: prdata = DATA_W'(cfg.value_cutoff);
      default: prdata = '0;
    endcase
  end

  // Stage enables: a stage loads when it is empty or its successor moves,
  // so bubbles collapse and a stalled output holds only what is behind it.
  always_comb begin
    en[NV-1] = !vld[NV-1] || !out_stall;
    for (int k = NV - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NV; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall = !en[0];
  assign out_valid = vld[NV-1];

  hsvkey_front #(
    .HFB(HFB),
    .SFB(SFB),
    .XHW(XHW),
    .XSW(XSW)
  ) u_front (
    .clk(clk),
    .en_a(en[0]),
    .en_b(en[1]),
    .red(red),
    .green(green),
    .blue(blue),
    .xh(xh),
    .xs(xs),
    .dh(dh),
    .dm(dm),
    .side(side_b)
  );

  hsvkey_div #(
    .XW(XHW),
    .QWP(QWP),
    .NS(NS)
  ) u_div_hue (
    .clk(clk),
    .en(en[NS+1:2]),
    .num(xh),
    .den(dh),
    .quo(q_hue),
    .rem_nz(nz_hue)
  );

  hsvkey_div #(
    .XW(XSW),
    .QWP(QWP),
    .NS(NS)
  ) u_div_sat (
    .clk(clk),
    .en(en[NS+1:2]),
    .num(xs),
    .den(dm),
    .quo(q_sat),
    .rem_nz(nz_sat)
  );

  // Pixel facts ride beside the divider stages.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      side_p[0] <= side_b;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k+2]) begin
        side_p[k] <= side_p[k-1];
      end
    end
  end

  hsvkey_key #(
    .HFB(HFB),
    .SFB(SFB),
    .QWP(QWP)
  ) u_key (
    .clk(clk),
    .en(en[NV-1]),
    .q_hue(q_hue),
    .nz_hue(nz_hue),
    .q_sat(q_sat),
    .side(side_p[NS-1]),
    .cfg(cfg),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .key_intensity(key_intensity)
  );

endmodule

### rtl/hsvkey_checker.sv
// Port-level checks for the color key block and the bind that attaches them.
// Depends on hsvkey_pkg and rgb_to_hsv_color_key.
module hsvkey_checker
  import hsvkey_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic [HUE_W-1:0] hue,
  input logic [SAT_W-1:0] saturation,
  input logic [BYTE_W-1:0] brightness,
  input logic [BYTE_W-1:0] key_intensity
);

  // A stalled result transaction stays on the port unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hue) && $stable(saturation) &&
      $stable(brightness) && $stable(key_intensity))
    else $error("stalled result changed");

  // The key either blanks the pixel or passes its brightness.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_intensity == '0 || key_intensity == brightness)
    else $error("key intensity differs from brightness");

  // A black pixel is gray: no hue, no saturation, nothing keyed.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && brightness == '0 |-> hue == '0 && saturation == '0 &&
      key_intensity == '0)
    else $error("black pixel gave nonzero color");

  // Reset flushes the pipeline.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rgb_to_hsv_color_key hsvkey_checker u_hsvkey_checker (.*);

### bench/testbench.sv
// Self-checking testbench for the RGB to HSV color key block.
// Depends on hsvkey_pkg and rgb_to_hsv_color_key; it needs no files or arguments.
`timescale 1ns / 1ps

module testbench;
  import hsvkey_pkg::*;

  // Pipeline depth with the default fraction widths.
  localparam int PIPE_LATENCY = 6;
  localparam int HUE_UNIT = 60 << HUE_FRAC_DEF;
  localparam int HUE_TOP = 23039;
  localparam int SAT_TOP = 256;
  // An address with no register behind it.
  localparam logic [2:0] REG_SPARE = 3'd5;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [BYTE_W-1:0] brightness;
    logic [BYTE_W-1:0] key_intensity;
  } hsv_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] red = '0;
  logic [BYTE_W-1:0] green = '0;
  logic [BYTE_W-1:0] blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [BYTE_W-1:0] brightness;
  logic [BYTE_W-1:0] key_intensity;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // Shadow copy of the key registers and the pixels still in flight.
  cfg_t key_cfg;
  hsv_result_t expected_hsv_q[$];
  int error_count = 0;

  // Sender burst shape and receiver stall pattern.
  bit gaps_on = 1'b0;
  int burst_max = 8;
  int gap_max = 4;
  int burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_run = 0;

  rgb_to_hsv_color_key DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .key_intensity(key_intensity),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Free-running clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endtask

  // Expected HSV conversion and key decision for one pixel.
  function automatic hsv_result_t predict_hsv(input logic [BYTE_W-1:0] r, g, b);
    int mx, mn, d, diff, sector_base;
    bit pass;
    hsv_result_t res;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    d = mx - mn;
    res = '0;
    if (d != 0) begin
      res.saturation = SAT_W'((d << SAT_FRAC_DEF) / mx);
      // Red wins ties, then green; a negative red sector counts down from 360 degrees.
      if (r == mx) begin
        diff = int'(g) - int'(b);
        sector_base = (diff < 0) ? 6 : 0;
      end else if (g == mx) begin
        diff = int'(b) - int'(r);
        sector_base = 2;
      end else begin
        diff = int'(r) - int'(g);
        sector_base = 4;
      end
      res.hue = HUE_W'((sector_base * HUE_UNIT * d + HUE_UNIT * diff) / d);
    end
    res.brightness = BYTE_W'(mx);
    pass = res.hue >= key_cfg.hue_low && res.hue <= key_cfg.hue_high &&
           res.saturation >= key_cfg.sat_low && res.saturation <= key_cfg.sat_high &&
           res.brightness >= key_cfg.value_cutoff;
    res.key_intensity = pass ? res.brightness : '0;
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] shadow_reg(input logic [2:0] idx);
    case (idx)
      REG_HUE_LOW: return DATA_W'(key_cfg.hue_low);
      REG_HUE_HIGH: return DATA_W'(key_cfg.hue_high);
      REG_SAT_LOW: return DATA_W'(key_cfg.sat_low);
      REG_SAT_HIGH: return DATA_W'(key_cfg.sat_high);
      REG_VALUE_CUTOFF: return DATA_W'(key_cfg.value_cutoff);
      default: return '0;
    endcase
  endfunction

  // Sometimes sets junk above the register width, which the block must drop.
  function automatic logic [DATA_W-1:0] add_junk(input int value, input int width);
    logic [DATA_W-1:0] junk;
    junk = $urandom_range(0, 1) ? DATA_W'($urandom) << width : '0;
    return DATA_W'(value) | junk;
  endfunction

  // One configuration write: setup cycle, then access cycle.
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] word);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_HUE_LOW: key_cfg.hue_low = word[HUE_W-1:0];
      REG_HUE_HIGH: key_cfg.hue_high = word[HUE_W-1:0];
      REG_SAT_LOW: key_cfg.sat_low = word[SAT_W-1:0];
      REG_SAT_HIGH: key_cfg.sat_high = word[SAT_W-1:0];
      REG_VALUE_CUTOFF: key_cfg.value_cutoff = word[BYTE_W-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Read every register back and compare with the shadow copy.
  task automatic check_registers();
    logic [DATA_W-1:0] got;
    for (int i = REG_HUE_LOW; i <= REG_VALUE_CUTOFF; i++) begin
      @(posedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {3'(i), 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      if (got !== shadow_reg(3'(i))) begin
        flag_error($sformatf("register %0d reads %0d, expected %0d",
                             i, got, shadow_reg(3'(i))));
      end
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // Stop sending and wait until every pixel in flight has come out.
  task automatic wait_for_results();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (expected_hsv_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_key_config(input int hl, hh, sl, sh, vc);
    wait_for_results();
    write_reg(REG_HUE_LOW, add_junk(hl, HUE_W));
    write_reg(REG_HUE_HIGH, add_junk(hh, HUE_W));
    write_reg(REG_SAT_LOW, add_junk(sl, SAT_W));
    write_reg(REG_SAT_HIGH, add_junk(sh, SAT_W));
    write_reg(REG_VALUE_CUTOFF, add_junk(vc, BYTE_W));
    check_registers();
  endtask

  task automatic set_idling(input bit gaps, input stall_mode_t stall);
    gaps_on = gaps;
    burst_max = $urandom_range(0, 20);
    gap_max = $urandom_range(1, 8);
    stall_mode = stall;
  endtask

  // Send one pixel; the valid stays high inside a burst and drops for a gap.
  task automatic send_pixel(input logic [BYTE_W-1:0] r, g, b);
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (in_stall);
    expected_hsv_q.push_back(predict_hsv(r, g, b));
    if (!gaps_on || burst_left > 0) begin
      burst_left = (burst_left > 0) ? burst_left - 1 : 0;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, burst_max);
    end
  endtask

  // Random pixel, biased toward gray, tied channels and strong colors.
  task automatic send_random_pixel();
    logic [BYTE_W-1:0] c0, c1, c2;
    c0 = $urandom;
    c1 = $urandom;
    c2 = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        c1 = c0;
        c2 = c0;
      end
      1: c1 = c0;
      2: c2 = c1;
      3, 4: begin
        c0 = BYTE_W'(255 - $urandom_range(0, 40));
        c1 = BYTE_W'($urandom_range(0, 40));
      end
      default: ;
    endcase
    case ($urandom_range(0, 2))
      0: send_pixel(c0, c1, c2);
      1: send_pixel(c1, c2, c0);
      default: send_pixel(c2, c0, c1);
    endcase
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_run == 0) begin
          stall_run <= $urandom_range(1, 12);
          out_stall <= ~out_stall;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // Compare each result transaction with the oldest expected pixel.
  always @(posedge clk) begin : check_results
    hsv_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_hsv_q.size() == 0) begin
        flag_error($sformatf("unexpected result hue %0d sat %0d val %0d key %0d",
                             hue, saturation, brightness, key_intensity));
      end else begin
        want = expected_hsv_q.pop_front();
        if (hue !== want.hue || saturation !== want.saturation ||
            brightness !== want.brightness || key_intensity !== want.key_intensity) begin
          flag_error($sformatf(
            "expected hue %0d sat %0d val %0d key %0d, got hue %0d sat %0d val %0d key %0d",
            want.hue, want.saturation, want.brightness, want.key_intensity,
            hue, saturation, brightness, key_intensity));
        end
      end
    end
  end

  // Registers must come out of reset with their default values.
  task automatic test_register_defaults();
    key_cfg.hue_low = HUE_LOW_RST;
    key_cfg.hue_high = HUE_HIGH_RST;
    key_cfg.sat_low = SAT_LOW_RST;
    key_cfg.sat_high = SAT_HIGH_RST;
    key_cfg.value_cutoff = VALUE_CUTOFF_RST;
    check_registers();
  endtask

  // Hand-picked pixels under the default key settings.
  task automatic test_corner_pixels();
    set_idling(1'b0, STALL_NONE);
    send_pixel(8'd0, 8'd0, 8'd0);       // black
    send_pixel(8'd255, 8'd255, 8'd255); // white
    send_pixel(8'd128, 8'd128, 8'd128); // mid gray
    send_pixel(8'd255, 8'd0, 8'd0);     // pure red
    send_pixel(8'd0, 8'd255, 8'd0);     // pure green
    send_pixel(8'd0, 8'd0, 8'd255);     // pure blue
    send_pixel(8'd255, 8'd255, 8'd0);   // red and green tie, red wins
    send_pixel(8'd0, 8'd255, 8'd255);   // green and blue tie, green wins
    send_pixel(8'd255, 8'd0, 8'd255);   // red and blue tie, hue wraps
    send_pixel(8'd255, 8'd0, 8'd1);     // hue just under 360 degrees
    send_pixel(8'd255, 8'd1, 8'd0);     // hue just over 0
    send_pixel(8'd1, 8'd0, 8'd0);       // smallest colored pixel
    send_pixel(8'd255, 8'd254, 8'd254); // lowest saturation step
    send_pixel(8'd200, 8'd100, 8'd50);  // hue below the window
    send_pixel(8'd200, 8'd150, 8'd50);  // hue on the low window edge
    send_pixel(8'd128, 8'd96, 8'd32);   // brightness on the cutoff
    send_pixel(8'd127, 8'd95, 8'd31);   // brightness one under the cutoff
    send_pixel(8'd90, 8'd255, 8'd0);    // hue just inside the high edge
    send_pixel(8'd80, 8'd255, 8'd0);    // hue just past the high edge
    send_pixel(8'd0, 8'd128, 8'd255);   // blue sector
    send_pixel(8'd17, 8'd34, 8'd51);    // dark blue-ish
    send_pixel(8'd255, 8'd200, 8'd200); // saturation under the window
    wait_for_results();
  endtask

  // Window edge settings: wide open, inverted, over range and tight.
  task automatic test_window_extremes();
    set_idling(1'b1, STALL_RANDOM);
    set_key_config(0, HUE_TOP, 0, SAT_TOP, 0);
    repeat (50) send_random_pixel();
    set_key_config(0, 32767, 0, 511, 255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    repeat (40) send_random_pixel();
    set_key_config(HUE_TOP, 0, 0, SAT_TOP, 0);
    repeat (40) send_random_pixel();
    set_key_config(0, HUE_TOP, SAT_TOP, 0, 0);
    repeat (40) send_random_pixel();
    // Only pixels with hue 0 pass; grays pass too.
    set_key_config(0, 0, 0, SAT_TOP, 0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0);
    repeat (40) send_random_pixel();
    set_key_config(HUE_TOP, HUE_TOP, SAT_TOP, SAT_TOP, 255);
    send_pixel(8'd255, 8'd0, 8'd1);
    repeat (30) send_random_pixel();
    // A write to an empty address must leave every register alone.
    wait_for_results();
    write_reg(REG_SPARE, DATA_W'($urandom));
    check_registers();
    repeat (30) send_random_pixel();
    wait_for_results();
  endtask

  // Long random traffic over random key settings and idle patterns.
  task automatic test_random_traffic();
    int hl, hh, sl, sh;
    for (int phase = 0; phase < 9; phase++) begin
      hl = $urandom_range(0, HUE_TOP);
      hh = $urandom_range(hl, HUE_TOP);
      sl = $urandom_range(0, SAT_TOP);
      sh = $urandom_range(sl, SAT_TOP);
      if ($urandom_range(0, 5) == 0) begin
        hh = $urandom_range(0, hl);
      end
      if ($urandom_range(0, 5) == 0) begin
        sh = 511;
      end
      set_key_config(hl, hh, sl, sh, $urandom_range(0, 255));
      set_idling($urandom_range(0, 3) != 0, stall_mode_t'($urandom_range(0, 2)));
      repeat (90) send_random_pixel();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_register_defaults();
    test_corner_pixels();
    test_window_extremes();
    test_random_traffic();
    stall_mode = STALL_NONE;
    wait_for_results();
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hsvkey_pkg.sv
rtl/hsvkey_front.sv
rtl/hsvkey_div.sv
rtl/hsvkey_key.sv
rtl/rgb_to_hsv_color_key.sv
rtl/hsvkey_checker.sv
bench/testbench.sv
